>>> hw/rtl/tsv_column_range_dropper_unit_assert.svh
// assertion macros for the column range dropper
`ifndef TSV_COLUMN_RANGE_DROPPER_UNIT_ASSERT_SVH
`define TSV_COLUMN_RANGE_DROPPER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define TCRD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcrd assertion failed");
`define TCRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcrd assertion failed");
`else
`define TCRD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TCRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/tcrd_pkg.sv
package tcrd_pkg;

    localparam int MAX_RANGES_DEFAULT  = 4;
    localparam int COLUMN_BITS_DEFAULT = 16;

    localparam int RANGE_REGS = 4;
    localparam int PTR_BITS   = 3;
    localparam int ADDR_BITS  = 5;

    localparam logic [15:0] CH_TAB = 16'd9;
    localparam logic [15:0] CH_LF  = 16'd10;
    localparam logic [15:0] CH_CR  = 16'd13;

    localparam logic [15:0] QUOTE_CHAR_RESET = 16'd34;

    typedef enum logic [2:0] {
        REG_QUOTE_CHAR   = 3'd0,
        REG_NL_IN_QUOTES = 3'd1,
        REG_RANGE_COUNT  = 3'd2,
        REG_RANGE_A      = 3'd3,
        REG_RANGE_B      = 3'd4,
        REG_RANGE_C      = 3'd5,
        REG_RANGE_D      = 3'd6
    } reg_idx_t;

endpackage

>>> hw/rtl/tsv_column_range_dropper_unit.sv
// tsv column range dropper
// input channel: text_valid / text_ready with text_char and buffer_end, one
//   utf-16 code unit per beat; buffer_end marks the last beat of a buffer
// output channel: result_valid / result_ready with kept_char, keep,
//   result_last and buffer_changed, exactly one result beat per input beat
// result beats are registered, valid in the cycle after the input is taken
// throughput: one beat per cycle; the column state is updated in the same
//   cycle the beat is taken, and the result register frees each cycle it is
//   drained, so text_ready stays high while result_ready is high
// receiver stall: the result register holds its beat and text_ready drops
//   until the beat is taken; nothing is lost or repeated
// configuration: pready is always high; apb write of registers at byte
//   address 4*i, done by the user only while the stream idles, not enforced
// reset: rst_n clears the registers to their defaults and the column state
//   to the start of a line; after a buffer_end beat the column state returns
//   to the start of a line as well
`include "tsv_column_range_dropper_unit_assert.svh"

module tsv_column_range_dropper_unit #(
    parameter int MAX_RANGES  = tcrd_pkg::MAX_RANGES_DEFAULT,
    parameter int COLUMN_BITS = tcrd_pkg::COLUMN_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcrd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           text_valid,
    output logic                           text_ready,
    input  logic [15:0]                    text_char,
    input  logic                           buffer_end,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [15:0]                    kept_char,
    output logic                           keep,
    output logic                           result_last,
    output logic                           buffer_changed
);
    import tcrd_pkg::*;

    localparam int LIMIT = (MAX_RANGES < RANGE_REGS) ? MAX_RANGES : RANGE_REGS;
    localparam int CMP_W = (COLUMN_BITS + 1 > 17) ? COLUMN_BITS + 1 : 17;
    localparam logic [PTR_BITS-1:0] LIMIT_P = PTR_BITS'(LIMIT);
    localparam logic [COLUMN_BITS-1:0] COL_TOP = '1;

    // configuration registers
    logic [15:0]          quote_char_reg;
    logic                 nl_in_quotes_reg;
    logic [2:0]           range_count_reg;
    logic [31:0]          range_reg [RANGE_REGS];
    logic                 cfg_write;
    reg_idx_t             cfg_idx;

    // column state
    logic                   quoted_reg, quoted_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [PTR_BITS-1:0]    ptr_reg, ptr_next;
    logic                   at_start_reg, at_start_next;
    logic                   col_kept_reg, col_kept_next;
    logic                   dropped_reg, dropped_next;

    // result register
    logic        out_valid_reg;
    logic [15:0] out_char_reg;
    logic        out_keep_reg;
    logic        out_last_reg;
    logic        out_changed_reg;

    logic                   accept;
    logic                   eol, tab, is_quote, term, keep_now;
    logic [PTR_BITS-1:0]    n_use, ptr_open;
    logic [CMP_W-1:0]       col1;
    logic [RANGE_REGS-1:0]  past_end, at_first;
    logic                   advance, kept_open;
    logic [COLUMN_BITS-1:0] col_bump;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_char_reg   <= QUOTE_CHAR_RESET;
            nl_in_quotes_reg <= 1'b1;
            range_count_reg  <= '0;
            for (int i = 0; i < RANGE_REGS; i++)
            begin
                range_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_QUOTE_CHAR:   quote_char_reg   <= pwdata[15:0];
                REG_NL_IN_QUOTES: nl_in_quotes_reg <= pwdata[0];
                REG_RANGE_COUNT:  range_count_reg  <= pwdata[2:0];
                REG_RANGE_A:      range_reg[0]     <= pwdata;
                REG_RANGE_B:      range_reg[1]     <= pwdata;
                REG_RANGE_C:      range_reg[2]     <= pwdata;
                REG_RANGE_D:      range_reg[3]     <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_QUOTE_CHAR:   prdata = {16'd0, quote_char_reg};
            REG_NL_IN_QUOTES: prdata = {31'd0, nl_in_quotes_reg};
            REG_RANGE_COUNT:  prdata = {29'd0, range_count_reg};
            REG_RANGE_A:      prdata = range_reg[0];
            REG_RANGE_B:      prdata = range_reg[1];
            REG_RANGE_C:      prdata = range_reg[2];
            REG_RANGE_D:      prdata = range_reg[3];
            default:          prdata = '0;
        endcase
    end

    assign text_ready = !out_valid_reg || result_ready;
    assign accept     = text_valid && text_ready;

    // range compares, one lane per range register
    assign col1 = CMP_W'(col_reg) + CMP_W'(1);

    always_comb
    begin
        for (int i = 0; i < RANGE_REGS; i++)
        begin
            past_end[i] = col1 >  CMP_W'(range_reg[i][31:16]);
            at_first[i] = col1 >= CMP_W'(range_reg[i][15:0]);
        end
    end

    assign n_use     = (PTR_BITS'(range_count_reg) > LIMIT_P) ? LIMIT_P
                                                              : PTR_BITS'(range_count_reg);
    assign advance   = (ptr_reg < n_use) && past_end[ptr_reg[1:0]];
    assign ptr_open  = advance ? ptr_reg + PTR_BITS'(1) : ptr_reg;
    assign kept_open = !((ptr_open < n_use) && at_first[ptr_open[1:0]]);
    assign col_bump  = (col_reg != COL_TOP) ? col_reg + COLUMN_BITS'(1) : col_reg;

    assign eol      = (text_char == CH_LF) || (text_char == CH_CR);
    assign tab      = (text_char == CH_TAB);
    assign is_quote = (text_char == quote_char_reg);
    assign term     = nl_in_quotes_reg ? (!quoted_reg && (eol || tab))
                                       : (eol || (!quoted_reg && tab));

    always_comb
    begin
        quoted_next   = quoted_reg;
        col_next      = col_reg;
        ptr_next      = ptr_reg;
        at_start_next = at_start_reg;
        col_kept_next = col_kept_reg;
        keep_now      = 1'b1;
        if (at_start_reg)
        begin
            if (eol)
            begin
                col_next = '0;
                ptr_next = '0;
            end
            else
            begin
                ptr_next      = ptr_open;
                col_kept_next = kept_open;
                if (tab)
                begin
                    quoted_next = 1'b0;
                    col_next    = col_bump;
                end
                else
                begin
                    quoted_next   = is_quote;
                    keep_now      = kept_open;
                    at_start_next = 1'b0;
                end
            end
        end
        else if (term)
        begin
            if (tab)
            begin
                col_next = col_bump;
            end
            else
            begin
                col_next = '0;
                ptr_next = '0;
            end
            at_start_next = 1'b1;
        end
        else
        begin
            quoted_next = quoted_reg ^ is_quote;
            keep_now    = col_kept_reg;
        end
        dropped_next = dropped_reg || !keep_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoted_reg    <= 1'b0;
            col_reg       <= '0;
            ptr_reg       <= '0;
            at_start_reg  <= 1'b1;
            col_kept_reg  <= 1'b1;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (buffer_end)
                begin
                    quoted_reg   <= 1'b0;
                    col_reg      <= '0;
                    ptr_reg      <= '0;
                    at_start_reg <= 1'b1;
                    col_kept_reg <= 1'b1;
                    dropped_reg  <= 1'b0;
                end
                else
                begin
                    quoted_reg   <= quoted_next;
                    col_reg      <= col_next;
                    ptr_reg      <= ptr_next;
                    at_start_reg <= at_start_next;
                    col_kept_reg <= col_kept_next;
                    dropped_reg  <= dropped_next;
                end
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_char_reg    <= text_char;
            out_keep_reg    <= keep_now;
            out_last_reg    <= buffer_end;
            out_changed_reg <= buffer_end && dropped_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign kept_char      = out_char_reg;
    assign keep           = out_keep_reg;
    assign result_last    = out_last_reg;
    assign buffer_changed = out_changed_reg;

    `TCRD_ASSERT_IMPL(a_changed_only_last, clk, rst_n, result_valid && !result_last, !buffer_changed)
    `TCRD_ASSERT_IMPL(a_drop_on_last, clk, rst_n, result_valid && result_last && !keep, buffer_changed)
    `TCRD_ASSERT_IMPL(a_ptr_bound, clk, rst_n, 1'b1, ptr_reg <= LIMIT_P)
    `TCRD_ASSERT_NEXT(a_clear_after_last, clk, rst_n, accept && buffer_end, at_start_reg && !dropped_reg && ptr_reg == '0)

endmodule

>>> bench/tsv_column_range_dropper_unit_test.sv
`timescale 1ns / 100ps

import tcrd_pkg::*;

typedef struct packed {
    logic [15:0] ch;
    logic        keep;
    logic        last;
    logic        changed;
} char_verdict_t;

class column_filter_board;
    logic [15:0]                    quote_char;
    logic                           nl_in_quotes;
    logic [2:0]                     range_count;
    logic [31:0]                    range_reg [RANGE_REGS];
    logic                           quoted;
    logic [COLUMN_BITS_DEFAULT-1:0] column_index;
    int                             range_pointer;
    logic                           at_column_start;
    logic                           column_kept;
    logic                           dropped_any;
    char_verdict_t                  verdicts[$];
    int                             errors;

    function new();
        quote_char = QUOTE_CHAR_RESET;
        nl_in_quotes = 1'b1;
        range_count = 3'd0;
        foreach (range_reg[i])
            range_reg[i] = 32'd0;
        errors = 0;
        clear_buffer_state();
    endfunction

    function void clear_buffer_state();
        quoted = 1'b0;
        column_index = '0;
        range_pointer = 0;
        at_column_start = 1'b1;
        column_kept = 1'b1;
        dropped_any = 1'b0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] v);
        case (idx)
            REG_QUOTE_CHAR:   quote_char = v[15:0];
            REG_NL_IN_QUOTES: nl_in_quotes = v[0];
            REG_RANGE_COUNT:  range_count = v[2:0];
            REG_RANGE_A:      range_reg[0] = v;
            REG_RANGE_B:      range_reg[1] = v;
            REG_RANGE_C:      range_reg[2] = v;
            REG_RANGE_D:      range_reg[3] = v;
            default:          ;
        endcase
    endfunction

    function void bump_column();
        if (column_index != '1)
            column_index = column_index + 1'b1;
    endfunction

    // decide whether the new column is dropped, moving past at most one range
    function void open_column();
        int                           n;
        logic [COLUMN_BITS_DEFAULT:0] col1;
        n = (range_count > MAX_RANGES_DEFAULT) ? MAX_RANGES_DEFAULT : range_count;
        if (n > RANGE_REGS)
            n = RANGE_REGS;
        col1 = {1'b0, column_index} + 1'b1;
        if (range_pointer < n && col1 > range_reg[range_pointer][31:16])
            range_pointer++;
        column_kept = 1'b1;
        if (range_pointer < n && col1 >= range_reg[range_pointer][15:0])
            column_kept = 1'b0;
    endfunction

    function void note_text(logic [15:0] c, logic last);
        logic          eol;
        logic          tab;
        logic          term;
        logic          keep_it;
        char_verdict_t v;
        eol = (c == CH_LF) || (c == CH_CR);
        tab = (c == CH_TAB);
        if (at_column_start)
        begin
            if (eol)
            begin
                keep_it = 1'b1;
                column_index = '0;
                range_pointer = 0;
            end
            else
            begin
                open_column();
                quoted = 1'b0;
                if (tab)
                begin
                    keep_it = 1'b1;
                    bump_column();
                end
                else
                begin
                    if (c == quote_char)
                        quoted = ~quoted;
                    keep_it = column_kept;
                    at_column_start = 1'b0;
                end
            end
        end
        else
        begin
            term = nl_in_quotes ? (!quoted && (eol || tab)) : (eol || (!quoted && tab));
            if (term)
            begin
                keep_it = 1'b1;
                if (tab)
                    bump_column();
                else
                begin
                    column_index = '0;
                    range_pointer = 0;
                end
                at_column_start = 1'b1;
            end
            else
            begin
                if (c == quote_char)
                    quoted = ~quoted;
                keep_it = column_kept;
            end
        end
        if (!keep_it)
            dropped_any = 1'b1;
        v.ch = c;
        v.keep = keep_it;
        v.last = last;
        v.changed = last ? dropped_any : 1'b0;
        verdicts.push_back(v);
        if (last)
            clear_buffer_state();
    endfunction

    function void flag(string what, logic [15:0] want, logic [15:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch %s at %0t: expected %h, got %h", what, $time, want, got);
    endfunction

    function void check_result(logic [15:0] c, logic k, logic l, logic chg);
        char_verdict_t v;
        if (verdicts.size() == 0)
            flag("result beat with nothing pending", 16'h0000, c);
        else
        begin
            v = verdicts.pop_front();
            if (c !== v.ch)
                flag("kept_char", v.ch, c);
            if (k !== v.keep)
                flag("keep", v.keep, k);
            if (l !== v.last)
                flag("result_last", v.last, l);
            if (chg !== v.changed)
                flag("buffer_changed", v.changed, chg);
        end
    endfunction

    function int pending();
        return verdicts.size();
    endfunction
endclass

module tsv_column_range_dropper_unit_test;

    localparam logic [2:0] REG_SPARE      = 3'd7;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         RANDOM_ITEMS   = 1100;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 text_valid;
    logic                 text_ready;
    logic [15:0]          text_char;
    logic                 buffer_end;
    logic                 result_valid;
    logic                 result_ready;
    logic [15:0]          kept_char;
    logic                 keep;
    logic                 result_last;
    logic                 buffer_changed;

    column_filter_board board;
    bit                 steady;
    int                 sent_count;
    int                 random_start;
    int                 sink_hold;
    int                 quiet_cycles;
    logic [15:0]        line_q[$];

    tsv_column_range_dropper_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .text_valid     (text_valid),
        .text_ready     (text_ready),
        .text_char      (text_char),
        .buffer_end     (buffer_end),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kept_char      (kept_char),
        .keep           (keep),
        .result_last    (result_last),
        .buffer_changed (buffer_changed)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] letter();
        return 16'($urandom_range(16'h0061, 16'h007a));
    endfunction

    function automatic logic [15:0] quoted_filler();
        case ($urandom_range(0, 5))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_CR;
            3:       return board.quote_char;
            default: return letter();
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            result_ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            if (!steady)
                sink_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_result(kept_char, keep, result_last, buffer_changed);
    end

    always @(posedge clk)
    begin
        if ((text_valid && text_ready) || (result_valid && result_ready) ||
            (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_register(idx, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_char(input logic [15:0] c, input logic last);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_valid <= 1'b1;
        text_char  <= c;
        buffer_end <= last;
        do @(posedge clk); while (!text_ready);
        board.note_text(c, last);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_line_q(input bit complete);
        foreach (line_q[i])
            send_char(line_q[i], complete && (i == line_q.size() - 1));
    endtask

    // stream idle and every result beat back before the registers change
    task automatic settle_stream();
        text_valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic program_random_setup();
        logic [15:0] q;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [31:0] v;
        int          r;
        int          base;
        r = $urandom_range(0, 99);
        if (r < 60)
            q = 16'd34;
        else if (r < 70)
            q = 16'd39;
        else if (r < 76)
            q = CH_TAB;
        else if (r < 78)
            q = CH_LF;
        else if (r < 80)
            q = CH_CR;
        else if (r < 85)
            q = 16'h0000;
        else if (r < 90)
            q = 16'hffff;
        else
            q = 16'($urandom);
        write_reg(REG_QUOTE_CHAR, {16'($urandom), q});
        write_reg(REG_NL_IN_QUOTES, $urandom);
        if ($urandom_range(0, 4) == 0)
            write_reg(REG_RANGE_COUNT, {29'($urandom), 3'($urandom_range(5, 7))});
        else
            write_reg(REG_RANGE_COUNT, {29'($urandom), 3'($urandom_range(0, 4))});
        base = $urandom_range(1, 3);
        for (int i = 0; i < RANGE_REGS; i++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                v = $urandom;
            else if (r == 1)
                v = 32'd0;
            else if (r == 2)
                v = {16'hffff, 16'(base)};
            else
            begin
                lo = 16'(base + $urandom_range(0, 2));
                hi = lo + 16'($urandom_range(0, 2));
                v = {hi, lo};
                base = hi + 1 + $urandom_range(0, 2);
            end
            write_reg(3'(REG_RANGE_A + i), v);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, $urandom);
    endtask

    task automatic send_random_buffer(input bit complete);
        int lines;
        int cols;
        int len;
        line_q.delete();
        lines = $urandom_range(1, 4);
        for (int ln = 0; ln < lines; ln++)
        begin
            cols = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
            for (int col = 0; col < cols; col++)
            begin
                if (col > 0)
                    line_q.push_back(CH_TAB);
                len = $urandom_range(0, 4);
                case ($urandom_range(0, 9))
                    0:
                        ;
                    1, 2, 3, 4, 5:
                        repeat (len) line_q.push_back(letter());
                    6, 7:
                    begin
                        line_q.push_back(board.quote_char);
                        repeat (len) line_q.push_back(quoted_filler());
                        // sometimes the closing quote is missing
                        if ($urandom_range(0, 4) != 0)
                            line_q.push_back(board.quote_char);
                    end
                    default:
                        repeat (len) line_q.push_back(16'($urandom));
                endcase
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    line_q.push_back(CH_LF);
                5, 6:
                    line_q.push_back(CH_CR);
                7, 8:
                begin
                    line_q.push_back(CH_CR);
                    line_q.push_back(CH_LF);
                end
                default:
                    ;
            endcase
        end
        if (line_q.size() == 0)
            line_q.push_back(letter());
        send_line_q(complete);
    endtask

    initial
    begin
        board = new();
        steady = 1'b0;
        sent_count = 0;
        sink_hold = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = 32'd0;
        text_valid = 1'b0;
        text_char = 16'd0;
        buffer_end = 1'b0;
        result_ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: keep all, newline inside quotes stays in the field
        line_q = '{16'd34, CH_LF, 16'd34, CH_TAB, CH_CR, 16'h0061};
        send_line_q(1'b1);
        settle_stream();

        write_reg(REG_QUOTE_CHAR, 32'd34);
        write_reg(REG_NL_IN_QUOTES, 32'd1);
        write_reg(REG_RANGE_COUNT, 32'd2);
        write_reg(REG_RANGE_A, {16'd2, 16'd2});
        write_reg(REG_RANGE_B, {16'd5, 16'd4});
        write_reg(REG_RANGE_C, 32'hffff_ffff);
        write_reg(REG_RANGE_D, 32'd0);
        write_reg(REG_SPARE, 32'h1234_5678);
        line_q = '{16'h0078, CH_TAB, 16'd34, CH_LF, 16'd34, CH_TAB, CH_TAB, 16'h0079,
                   CH_TAB, 16'h007a, CH_LF, 16'hffff, CH_TAB, 16'h0000};
        send_line_q(1'b1);
        settle_stream();

        // quote equal to tab, newline always ends the line, oversized count, zero fields
        write_reg(REG_QUOTE_CHAR, {16'hffff, CH_TAB});
        write_reg(REG_NL_IN_QUOTES, 32'd0);
        write_reg(REG_RANGE_COUNT, 32'd7);
        write_reg(REG_RANGE_A, 32'd0);
        write_reg(REG_RANGE_B, {16'hffff, 16'h0000});
        line_q = '{16'h0061, CH_TAB, 16'd34, CH_CR, CH_TAB, 16'h0062};
        send_line_q(1'b1);
        settle_stream();

        random_start = sent_count;
        while (sent_count - random_start < RANDOM_ITEMS)
        begin
            program_random_setup();
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 6)) send_random_buffer(1'b1);
            // leave a buffer open across the next register writes
            if ($urandom_range(0, 3) == 0)
                send_random_buffer(1'b0);
            settle_stream();
        end

        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
